// ===== rtl/core/perspective_point_projection_macros.svh =====
// Assertion macros used by the projection core in perspective_point_projection.sv.
`ifndef PERSPECTIVE_POINT_PROJECTION_MACROS_SVH
`define PERSPECTIVE_POINT_PROJECTION_MACROS_SVH

`define PPP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define PPP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ppp_pkg.sv =====
package ppp_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned ViewW = 15;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROW0_C01 = 3'd0,
    CFG_ROW0_C23 = 3'd1,
    CFG_ROW1_C01 = 3'd2,
    CFG_ROW1_C23 = 3'd3,
    CFG_ROW3_C01 = 3'd4,
    CFG_ROW3_C23 = 3'd5,
    CFG_VIEW_W   = 3'd6,
    CFG_VIEW_H   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_req_t;

  typedef struct packed {
    logic               visible;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
  } out_rsp_t;

endpackage

// ===== rtl/core/perspective_point_projection.sv =====
// An accepted request runs through stages 1 to 4, the divider and the output register.
// Throughput: one request per cycle; the whole pipeline advances together and holds on a stall.
// The rate is set by the 9 parallel 32x32 multipliers and the 32-stage divider, one bit a stage.
// Reset (asynchronous, active low) clears all valid bits and loads the identity matrix
// and a 640x480 viewport.
`include "perspective_point_projection_macros.svh"

module perspective_point_projection (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  ppp_pkg::in_req_t                 in_req_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output ppp_pkg::out_rsp_t                out_rsp_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ppp_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [ppp_pkg::CfgDataW-1:0]     cfg_data_i
);
  import ppp_pkg::*;

  localparam int unsigned DivSteps = 32;
  localparam logic signed [62:0] WMin = 63'sd107374183;

  typedef struct packed {
    logic [61:0] rem;
    logic [31:0] lo;
    logic [31:0] quo;
    logic        neg;
    logic        ovf;
  } div_t;

  typedef struct packed {
    logic        vis;
    logic [61:0] den;
    div_t        dx;
    div_t        dy;
  } dstage_t;

  function automatic div_t div_step(div_t s, logic [61:0] den);
    div_t        r;
    logic [62:0] t;
    r = s;
    t = {s.rem, s.lo[31]};
    r.lo = {s.lo[30:0], 1'b0};
    if (t >= {1'b0, den}) begin
      r.rem = 62'(t - {1'b0, den});
      r.quo = {s.quo[30:0], 1'b1};
    end else begin
      r.rem = t[61:0];
      r.quo = {s.quo[30:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_coord(div_t s);
    logic [31:0] r;
    if (!s.neg) begin
      r = (s.ovf || s.quo[31]) ? 32'h7fff_ffff : s.quo;
    end else begin
      r = (s.ovf || (s.quo > 32'h8000_0000)) ? 32'h8000_0000 : 32'(-s.quo);
    end
    return r;
  endfunction

  logic [63:0] m_q [6];
  logic [ViewW-1:0] vw_q, vh_q;

  logic en;
  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q[0] <= 64'd65536;
      m_q[1] <= 64'd0;
      m_q[2] <= 64'd281474976710656;
      m_q[3] <= 64'd0;
      m_q[4] <= 64'd0;
      m_q[5] <= 64'd281474976710656;
      vw_q   <= 15'd640;
      vh_q   <= 15'd480;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ROW0_C01: m_q[0] <= cfg_data_i;
        CFG_ROW0_C23: m_q[1] <= cfg_data_i;
        CFG_ROW1_C01: m_q[2] <= cfg_data_i;
        CFG_ROW1_C23: m_q[3] <= cfg_data_i;
        CFG_ROW3_C01: m_q[4] <= cfg_data_i;
        CFG_ROW3_C23: m_q[5] <= cfg_data_i;
        CFG_VIEW_W:   vw_q   <= cfg_data_i[ViewW-1:0];
        CFG_VIEW_H:   vh_q   <= cfg_data_i[ViewW-1:0];
        default:      ;
      endcase
    end
  end

  // Stage 1: matrix products, floored to 30 fractional bits.
  logic signed [61:0] prod_q [3][3];
  logic signed [45:0] c3_q [3];
  logic               v1_q;

  // Stage 2: clip sums.
  logic signed [62:0] cx_q, cy_q, cw_q;
  logic               v2_q;

  // Stage 3: numerator magnitudes and visibility.
  logic [62:0] magx_q, magy_q;
  logic        negx_q, negy_q, vis3_q;
  logic [61:0] den3_q;
  logic        v3_q;

  // Stage 4: scaled numerators.
  logic [77:0] px_q, py_q;
  logic        negx4_q, negy4_q, vis4_q;
  logic [61:0] den4_q;
  logic        v4_q;

  dstage_t dst_q [DivSteps+1];
  logic    dvld_q [DivSteps+1];

  logic signed [63:0] prod_d [3][3];
  logic signed [63:0] numx_d, numy_d;
  logic [77:0]        px_d, py_d;
  div_t               dx0_d, dy0_d;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      prod_d[r][0] = $signed(m_q[2*r][31:0]) * in_req_i.pos_x;
      prod_d[r][1] = $signed(m_q[2*r][63:32]) * in_req_i.pos_y;
      prod_d[r][2] = $signed(m_q[2*r+1][31:0]) * in_req_i.pos_z;
    end
    numx_d = 64'(cw_q) + 64'(cx_q);
    numy_d = 64'(cw_q) - 64'(cy_q);
    px_d = magx_q * vw_q;
    py_d = magy_q * vh_q;
    dx0_d.rem = {1'b0, px_q[77:17]};
    dx0_d.lo  = {px_q[16:0], 15'd0};
    dx0_d.quo = '0;
    dx0_d.neg = negx4_q;
    dx0_d.ovf = ({1'b0, px_q[77:17]} >= den4_q);
    dy0_d.rem = {1'b0, py_q[77:17]};
    dy0_d.lo  = {py_q[16:0], 15'd0};
    dy0_d.quo = '0;
    dy0_d.neg = negy4_q;
    dy0_d.ovf = ({1'b0, py_q[77:17]} >= den4_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      for (int k = 0; k <= DivSteps; k++) dvld_q[k] <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      dvld_q[0] <= v4_q;
      for (int k = 0; k < DivSteps; k++) dvld_q[k+1] <= dvld_q[k];
      out_valid_o <= dvld_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) prod_q[r][c] <= 62'(prod_d[r][c] >>> 2);
        c3_q[r] <= {$signed(m_q[2*r+1][63:32]), 14'd0};
      end
      cx_q <= 63'(prod_q[0][0]) + 63'(prod_q[0][1]) + 63'(prod_q[0][2]) + 63'(c3_q[0]);
      cy_q <= 63'(prod_q[1][0]) + 63'(prod_q[1][1]) + 63'(prod_q[1][2]) + 63'(c3_q[1]);
      cw_q <= 63'(prod_q[2][0]) + 63'(prod_q[2][1]) + 63'(prod_q[2][2]) + 63'(c3_q[2]);
      negx_q <= numx_d[63];
      negy_q <= numy_d[63];
      magx_q <= numx_d[63] ? 63'(-numx_d) : numx_d[62:0];
      magy_q <= numy_d[63] ? 63'(-numy_d) : numy_d[62:0];
      vis3_q <= (cw_q >= WMin);
      den3_q <= cw_q[61:0];
      px_q <= px_d;
      py_q <= py_d;
      negx4_q <= negx_q;
      negy4_q <= negy_q;
      vis4_q <= vis3_q;
      den4_q <= den3_q;
      dst_q[0].vis <= vis4_q;
      dst_q[0].den <= den4_q;
      dst_q[0].dx  <= dx0_d;
      dst_q[0].dy  <= dy0_d;
      for (int k = 0; k < DivSteps; k++) begin
        dst_q[k+1].vis <= dst_q[k].vis;
        dst_q[k+1].den <= dst_q[k].den;
        dst_q[k+1].dx  <= div_step(dst_q[k].dx, dst_q[k].den);
        dst_q[k+1].dy  <= div_step(dst_q[k].dy, dst_q[k].den);
      end
      out_rsp_o.visible  <= dst_q[DivSteps].vis;
      out_rsp_o.screen_x <= dst_q[DivSteps].vis ? sat_coord(dst_q[DivSteps].dx) : 32'd0;
      out_rsp_o.screen_y <= dst_q[DivSteps].vis ? sat_coord(dst_q[DivSteps].dy) : 32'd0;
    end
  end

  `PPP_ASSERT(a_hidden_zero, !(out_valid_o && !out_rsp_o.visible) || (out_rsp_o.screen_x == 32'd0 && out_rsp_o.screen_y == 32'd0), "hidden point with nonzero screen coordinates")
  `PPP_ASSERT(a_ready_rule, in_ready_o == (!out_valid_o || out_ready_i), "input ready does not follow output stall")
  `PPP_ASSERT_IMP(a_stall_hold, out_valid_o && !out_ready_i, $stable(v1_q) && $stable(v4_q) && $stable(dvld_q[DivSteps]), "pipeline moved during a stall")
  `PPP_ASSERT_IMP(a_stage_feed, en && v4_q, dvld_q[0], "item lost entering the divider")

endmodule
